/* rtl/core/cbez_pkg.sv */
`default_nettype none

package cbez_pkg;

  // configuration register map
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_POINT    = 2'd0,
    REG_FIRST_CONTROL  = 2'd1,
    REG_SECOND_CONTROL = 2'd2,
    REG_END_POINT      = 2'd3
  } cfg_reg_t;

  localparam int NUM_CTRL = 4;  // control points p0..p3
  localparam int NUM_AXES = 3;  // x, y, z

endpackage

`default_nettype wire

/* rtl/core/cubic_bezier_point_and_tangent.sv */
`default_nettype none

// Cubic Bezier evaluator, 3D, fixed point. Four control points p0..p3 are
// loaded through the write port (index 0 start_point, 1 first_control,
// 2 second_control, 3 end_point; x in the low COORD_BITS, then y, then z, all
// signed). Each input transaction carries t in unsigned Q1.PARAM_FRAC_BITS,
// where 2^PARAM_FRAC_BITS is one and anything above saturates to one. Each
// output transaction gives the point B(t) and the derivative B'(t), both
// exact and then rounded to nearest, ties towards plus infinity. Throughput
// is one transaction per clock while the output is not stalled. Up to the output
// register, one stage saturates t, the first two de Casteljau levels take a
// multiply, an add and a difference stage each, and the last level a
// multiply and an add stage. The wider multiplies are cut into two halves
// over a multiply and an add stage. Every stage has its own ready, so bubbles
// collapse and a stalled output does not block intake while stages are free.
// Load the control points only while no transaction is in flight; the
// derived coefficients are registered from the control points after a write.

module cubic_bezier_point_and_tangent #(
  parameter int COORD_BITS      = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // configuration writes
  input  logic                                       cfg_we,
  input  logic [cbez_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [3*COORD_BITS-1:0]                    cfg_data,
  // input stream
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // tdata: curve_param, padded with zeros to whole bytes
  input  logic [((PARAM_FRAC_BITS+8)/8)*8-1:0]       s_axis_tdata,
  // output stream
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // tdata: point_x, point_y, point_z, tangent_x, tangent_y, tangent_z, zero pad
  output logic [((6*COORD_BITS+16)/8)*8-1:0]         m_axis_tdata
);

  localparam int C    = COORD_BITS;
  localparam int F    = PARAM_FRAC_BITS;
  localparam int NAX  = cbez_pkg::NUM_AXES;
  localparam int NCP  = cbez_pkg::NUM_CTRL;
  localparam int NSTG = 9;

  localparam int TW   = F + 1;        // t, unsigned
  localparam int TSW  = F + 2;        // t as a signed operand
  localparam int EW   = C + 1;        // first differences of control points
  localparam int DDW  = C + 2;        // second differences
  localparam int A1W  = C + F;        // point, level 1
  localparam int B1W  = C + F + 1;    // tangent, level 1
  localparam int FW   = C + F + 1;    // point level-1 differences
  localparam int HW   = C + F + 2;    // tangent level-1 difference
  localparam int A2W  = C + 2*F;      // point, level 2
  localparam int B2W  = C + 2*F + 1;  // tangent, level 2
  localparam int GW   = C + 2*F + 1;  // point level-2 difference
  localparam int A3W  = C + 3*F;      // point, level 3
  localparam int T3W  = C + 2*F + 3;  // three times tangent level 2
  localparam int TGW  = C + 3;        // rounded tangent

  // split points of the wide multiplies
  localparam int LF   = FW / 2;
  localparam int LH   = HW / 2;
  localparam int LG   = GW / 2;
  localparam int PHF  = A2W - LF;
  localparam int PLF  = LF + TW;
  localparam int PHH  = B2W - LH;
  localparam int PLH  = LH + TW;
  localparam int PHG  = A3W - LG;
  localparam int PLG  = LG + TW;

  localparam int OUTW = ((6*C+16)/8)*8;
  localparam int PADW = OUTW - 6*C - 9;

  localparam logic [TW-1:0]  T_ONE  = TW'(1) << F;
  localparam logic [A3W-1:0] HALF_P = A3W'(1) << (3*F-1);
  localparam logic [T3W-1:0] HALF_T = T3W'(1) << (2*F-1);

  // ---------------------------------------------------------------------
  // control points and derived differences
  // ---------------------------------------------------------------------
  logic [3*C-1:0]         ctl [NCP];
  logic signed [C-1:0]    pc  [NAX][NCP];
  logic signed [EW-1:0]   ce  [NAX][3];
  logic signed [DDW-1:0]  cdd [NAX][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCP; i++) ctl[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbez_pkg::REG_START_POINT:    ctl[0] <= cfg_data;
        cbez_pkg::REG_FIRST_CONTROL:  ctl[1] <= cfg_data;
        cbez_pkg::REG_SECOND_CONTROL: ctl[2] <= cfg_data;
        cbez_pkg::REG_END_POINT:      ctl[3] <= cfg_data;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < NAX; k++)
      for (int i = 0; i < NCP; i++)
        pc[k][i] = $signed(ctl[i][k*C +: C]);
  end

  // e_i = p(i+1) - p(i), dd_i = e(i+1) - e(i); registered from the control points
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NAX; k++) begin
        for (int i = 0; i < 3; i++) ce[k][i] <= '0;
        for (int i = 0; i < 2; i++) cdd[k][i] <= '0;
      end
    end else begin
      for (int k = 0; k < NAX; k++) begin
        for (int i = 0; i < 3; i++)
          ce[k][i] <= EW'(pc[k][i+1]) - EW'(pc[k][i]);
        for (int i = 0; i < 2; i++)
          cdd[k][i] <= DDW'(pc[k][i+2]) - DDW'(pc[k][i+1]) - DDW'(pc[k][i+1])
                       + DDW'(pc[k][i]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage handshake: per-stage ready so bubbles collapse
  // ---------------------------------------------------------------------
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] ld;
  logic [NSTG-1:0] vin;

  assign vin = {vld[NSTG-2:0], s_axis_tvalid};

  always_comb begin
    rdy[NSTG-1] = ~vld[NSTG-1] | m_axis_tready;
    for (int s = NSTG-2; s >= 0; s--) rdy[s] = ~vld[s] | rdy[s+1];
    ld = rdy & vin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 0; s < NSTG; s++)
        if (rdy[s]) vld[s] <= vin[s];
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld[NSTG-1];

  // ---------------------------------------------------------------------
  // datapath; lerp(a, b) = a * 2^F + (b - a) * t, exact for u = 1 - t
  // ---------------------------------------------------------------------
  logic [TW-1:0]          t_in;
  logic [TW-1:0]          t0, t1, t2, t3, t4, t5, t6;
  logic signed [TSW-1:0]  ts0, ts3, ts6;

  logic signed [A1W-1:0]  m1   [NAX][3];
  logic signed [B1W-1:0]  n1   [NAX][2];
  logic signed [A1W-1:0]  a1   [NAX][3];
  logic signed [B1W-1:0]  b1   [NAX][2];
  logic signed [FW-1:0]   f3   [NAX][2];
  logic signed [HW-1:0]   h3   [NAX];
  logic signed [A1W-1:0]  a13  [NAX][2];
  logic signed [B1W-1:0]  b13  [NAX];
  logic signed [PHF-1:0]  fph  [NAX][2];
  logic [PLF-1:0]         fpl  [NAX][2];
  logic signed [PHH-1:0]  hph  [NAX];
  logic [PLH-1:0]         hpl  [NAX];
  logic signed [A1W-1:0]  a14  [NAX][2];
  logic signed [B1W-1:0]  b14  [NAX];
  logic signed [A2W-1:0]  a2   [NAX][2];
  logic signed [B2W-1:0]  b2   [NAX];
  logic signed [GW-1:0]   g6   [NAX];
  logic signed [A2W-1:0]  a26  [NAX];
  logic [T3W-1:0]         tg6  [NAX];
  logic signed [PHG-1:0]  gph  [NAX];
  logic [PLG-1:0]         gpl  [NAX];
  logic signed [A2W-1:0]  a27  [NAX];
  logic [TGW-1:0]         tg7  [NAX];
  logic [A3W-1:0]         pt8  [NAX];
  logic [TGW-1:0]         tg8  [NAX];

  assign t_in = s_axis_tdata[TW-1:0];
  assign ts0  = $signed({1'b0, t0});
  assign ts3  = $signed({1'b0, t3});
  assign ts6  = $signed({1'b0, t6});

  // S0: saturate t
  always_ff @(posedge clk) begin
    if (ld[0]) t0 <= (t_in > T_ONE) ? T_ONE : t_in;
  end

  // S1: level-1 products
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      t1 <= t0;
      for (int k = 0; k < NAX; k++) begin
        for (int i = 0; i < 3; i++) m1[k][i] <= A1W'(ce[k][i]) * A1W'(ts0);
        for (int i = 0; i < 2; i++) n1[k][i] <= B1W'(cdd[k][i]) * B1W'(ts0);
      end
    end
  end

  // S2: level-1 sums
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      t2 <= t1;
      for (int k = 0; k < NAX; k++) begin
        for (int i = 0; i < 3; i++)
          a1[k][i] <= {pc[k][i], {F{1'b0}}} + m1[k][i];
        for (int i = 0; i < 2; i++)
          b1[k][i] <= {ce[k][i], {F{1'b0}}} + n1[k][i];
      end
    end
  end

  // S3: level-1 differences
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      t3 <= t2;
      for (int k = 0; k < NAX; k++) begin
        for (int i = 0; i < 2; i++) begin
          f3[k][i]  <= FW'(a1[k][i+1]) - FW'(a1[k][i]);
          a13[k][i] <= a1[k][i];
        end
        h3[k]  <= HW'(b1[k][1]) - HW'(b1[k][0]);
        b13[k] <= b1[k][0];
      end
    end
  end

  // S4: level-2 products, high and low halves
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      t4 <= t3;
      for (int k = 0; k < NAX; k++) begin
        for (int i = 0; i < 2; i++) begin
          fph[k][i] <= PHF'($signed(f3[k][i][FW-1:LF])) * PHF'(ts3);
          fpl[k][i] <= PLF'(f3[k][i][LF-1:0]) * PLF'(t3);
          a14[k][i] <= a13[k][i];
        end
        hph[k] <= PHH'($signed(h3[k][HW-1:LH])) * PHH'(ts3);
        hpl[k] <= PLH'(h3[k][LH-1:0]) * PLH'(t3);
        b14[k] <= b13[k];
      end
    end
  end

  // S5: level-2 sums
  always_ff @(posedge clk) begin
    if (ld[5]) begin
      t5 <= t4;
      for (int k = 0; k < NAX; k++) begin
        for (int i = 0; i < 2; i++)
          a2[k][i] <= {a14[k][i], {F{1'b0}}} + {fph[k][i], {LF{1'b0}}}
                      + A2W'(fpl[k][i]);
        b2[k] <= {b14[k], {F{1'b0}}} + {hph[k], {LH{1'b0}}} + B2W'(hpl[k]);
      end
    end
  end

  // S6: level-2 difference; tangent is 3 * quadratic, plus rounding half
  always_ff @(posedge clk) begin
    if (ld[6]) begin
      t6 <= t5;
      for (int k = 0; k < NAX; k++) begin
        g6[k]  <= GW'(a2[k][1]) - GW'(a2[k][0]);
        a26[k] <= a2[k][0];
        tg6[k] <= T3W'(b2[k]) + (T3W'(b2[k]) << 1) + HALF_T;
      end
    end
  end

  // S7: level-3 product halves
  always_ff @(posedge clk) begin
    if (ld[7]) begin
      for (int k = 0; k < NAX; k++) begin
        gph[k] <= PHG'($signed(g6[k][GW-1:LG])) * PHG'(ts6);
        gpl[k] <= PLG'(g6[k][LG-1:0]) * PLG'(t6);
        a27[k] <= a26[k];
        tg7[k] <= tg6[k][T3W-1:2*F];
      end
    end
  end

  // S8: output register; point sum carries its rounding half
  always_ff @(posedge clk) begin
    if (ld[8]) begin
      for (int k = 0; k < NAX; k++) begin
        pt8[k] <= {a27[k], {F{1'b0}}} + {gph[k], {LG{1'b0}}} + A3W'(gpl[k]) + HALF_P;
        tg8[k] <= tg7[k];
      end
    end
  end

  assign m_axis_tdata = {{PADW{1'b0}}, tg8[2], tg8[1], tg8[0],
                         pt8[2][A3W-1:3*F], pt8[1][A3W-1:3*F], pt8[0][A3W-1:3*F]};

endmodule

`default_nettype wire
